// ===== src/efc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// efc_pkg
// Types and constants shared by the Ethernet frame classifier modules.
// ----------------------------------------------------------------------------
package efc_pkg;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } efc_in_t;

  typedef struct packed {
    logic [3:0]  protocol_class;
    logic [1:0]  format_error;
    logic [7:0]  payload_start;
    logic [11:0] valid_bytes;
  } efc_out_t;

  // Header fields collected while a frame streams in
  typedef struct packed {
    logic [15:0] ether_kind;
    logic        has_vlan_tag;
    logic [3:0]  ip_header_words;
    logic [15:0] ip_total_length;
    logic [7:0]  ip_protocol;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [3:0]  tcp_header_words;
  } efc_hdr_t;

  typedef struct packed {
    logic [15:0] mms_port;
    logic [15:0] iec104_port;
    logic [15:0] sntp_port;
  } efc_ports_t;

  typedef enum logic [3:0] {
    CLS_OTHER  = 4'd0,
    CLS_ARP    = 4'd1,
    CLS_IP     = 4'd2,
    CLS_TCP    = 4'd3,
    CLS_UDP    = 4'd4,
    CLS_ICMP   = 4'd5,
    CLS_MMS    = 4'd6,
    CLS_IEC104 = 4'd7,
    CLS_SNTP   = 4'd8,
    CLS_GOOSE  = 4'd9,
    CLS_SV     = 4'd10,
    CLS_PTP    = 4'd11
  } efc_class_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_IP_LEN    = 2'd1,
    ERR_TCP_SHORT = 2'd2,
    ERR_UDP_SHORT = 2'd3
  } efc_err_t;

  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_MMS_PORT    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IEC104_PORT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SNTP_PORT   = 2'd2;

  localparam logic [15:0] MMS_PORT_RST    = 16'd102;
  localparam logic [15:0] IEC104_PORT_RST = 16'd2404;
  localparam logic [15:0] SNTP_PORT_RST   = 16'd123;

  localparam logic [15:0] ETH_VLAN  = 16'h8100;
  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [15:0] ETH_ARP   = 16'h0806;
  localparam logic [15:0] ETH_GOOSE = 16'h88B8;
  localparam logic [15:0] ETH_SV    = 16'h88BA;
  localparam logic [15:0] ETH_PTP   = 16'h88F7;

  localparam logic [7:0] IPP_ICMP = 8'h01;
  localparam logic [7:0] IPP_TCP  = 8'h06;
  localparam logic [7:0] IPP_UDP  = 8'h11;

  // Byte offsets in the frame
  localparam logic [7:0] OFS_TYPE_HI   = 8'd12;
  localparam logic [7:0] OFS_TYPE_LO   = 8'd13;
  localparam logic [7:0] OFS_INNER_HI  = 8'd16;
  localparam logic [7:0] OFS_INNER_LO  = 8'd17;
  localparam logic [7:0] LINK_LEN      = 8'd14;
  localparam logic [7:0] LINK_LEN_VLAN = 8'd18;
  localparam logic [7:0] OFS_IP_LEN_HI = 8'd2;
  localparam logic [7:0] OFS_IP_LEN_LO = 8'd3;
  localparam logic [7:0] OFS_IP_PROTO  = 8'd9;
  localparam logic [7:0] OFS_TCP_DOFF  = 8'd12;

  localparam logic [7:0] IP_HDR_MIN  = 8'd20;
  localparam logic [7:0] TCP_HDR_MIN = 8'd20;
  localparam logic [7:0] UDP_HDR_LEN = 8'd8;

endpackage
`default_nettype wire

// ===== src/efc_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// efc_parser
// Counts frame bytes, picks header fields out at their offsets and, on the
// last byte, hands the collected fields and the byte count to a summary
// register while clearing the working state for the next frame.
// ----------------------------------------------------------------------------
module efc_parser #(
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_take,
  input  wire efc_pkg::efc_in_t                       in_item,
  input  wire logic                                   sum_take,
  output logic                                        sum_valid,
  output efc_pkg::efc_hdr_t                           sum_hdr,
  output logic [$clog2(MAX_FRAME_BYTES+1)-1:0]        sum_count
);
  import efc_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int IDX_W = (CNT_W > 8) ? CNT_W : 8;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  efc_hdr_t         hdr_r, hdr_nxt;
  logic             sum_valid_r;
  efc_hdr_t         sum_hdr_r;
  logic [CNT_W-1:0] sum_cnt_r;

  logic [IDX_W-1:0] idx;
  logic [7:0]       b;
  logic [7:0]       link_len;
  logic [7:0]       t_start;
  logic [3:0]       hw;
  logic [15:0]      kind_lo;
  logic             frame_end;

  assign idx       = IDX_W'(cnt_r);
  assign b         = in_item.frame_byte;
  assign frame_end = in_take && in_item.last_byte;
  assign link_len  = hdr_r.has_vlan_tag ? LINK_LEN_VLAN : LINK_LEN;
  assign kind_lo   = hdr_r.ether_kind | {8'h00, b};

  // transport header start follows the header length seen on this very byte
  assign hw      = (idx == IDX_W'(link_len)) ? b[3:0] : hdr_r.ip_header_words;
  assign t_start = link_len + {2'b00, hw, 2'b00};

  always_comb begin
    hdr_nxt = hdr_r;
    cnt_nxt = cnt_r;
    if (cnt_r < CNT_MAX) begin
      cnt_nxt = cnt_r + 1'b1;
      if (idx == IDX_W'(OFS_TYPE_HI)) begin
        hdr_nxt.ether_kind = {b, 8'h00};
      end
      if (idx == IDX_W'(OFS_TYPE_LO)) begin
        // an outer tag: drop its type and wait for the inner one
        if (kind_lo == ETH_VLAN) begin
          hdr_nxt.has_vlan_tag = 1'b1;
          hdr_nxt.ether_kind   = '0;
        end else begin
          hdr_nxt.ether_kind = kind_lo;
        end
      end
      if (hdr_r.has_vlan_tag && idx == IDX_W'(OFS_INNER_HI)) begin
        hdr_nxt.ether_kind = {b, 8'h00};
      end
      if (hdr_r.has_vlan_tag && idx == IDX_W'(OFS_INNER_LO)) begin
        hdr_nxt.ether_kind = kind_lo;
      end
      if (idx == IDX_W'(link_len)) begin
        hdr_nxt.ip_header_words = b[3:0];
      end
      if (idx == IDX_W'(link_len + OFS_IP_LEN_HI)) begin
        hdr_nxt.ip_total_length[15:8] = b;
      end
      if (idx == IDX_W'(link_len + OFS_IP_LEN_LO)) begin
        hdr_nxt.ip_total_length[7:0] = b;
      end
      if (idx == IDX_W'(link_len + OFS_IP_PROTO)) begin
        hdr_nxt.ip_protocol = b;
      end
      if (idx == IDX_W'(t_start)) begin
        hdr_nxt.source_port[15:8] = b;
      end
      if (idx == IDX_W'(t_start + 8'd1)) begin
        hdr_nxt.source_port[7:0] = b;
      end
      if (idx == IDX_W'(t_start + 8'd2)) begin
        hdr_nxt.dest_port[15:8] = b;
      end
      if (idx == IDX_W'(t_start + 8'd3)) begin
        hdr_nxt.dest_port[7:0] = b;
      end
      if (idx == IDX_W'(t_start + OFS_TCP_DOFF)) begin
        hdr_nxt.tcp_header_words = b[7:4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      hdr_r       <= '0;
      sum_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        if (in_item.last_byte) begin
          cnt_r <= '0;
          hdr_r <= '0;
        end else begin
          cnt_r <= cnt_nxt;
          hdr_r <= hdr_nxt;
        end
      end
      if (frame_end) begin
        sum_valid_r <= 1'b1;
      end else if (sum_take) begin
        sum_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_end) begin
      sum_hdr_r <= hdr_nxt;
      sum_cnt_r <= cnt_nxt;
    end
  end

  assign sum_valid = sum_valid_r;
  assign sum_hdr   = sum_hdr_r;
  assign sum_count = sum_cnt_r;

endmodule
`default_nettype wire

// ===== src/efc_classifier.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// efc_classifier
// Turns one frame summary into a result: class by ethertype, IPv4 length
// checks and padding trim, transport split and payload offset.
// ----------------------------------------------------------------------------
module efc_classifier #(
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  wire efc_pkg::efc_hdr_t                      hdr,
  input  wire logic [$clog2(MAX_FRAME_BYTES+1)-1:0]   count,
  input  wire efc_pkg::efc_ports_t                    ports,
  output efc_pkg::efc_out_t                           result
);
  import efc_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int AW    = (CNT_W > 16) ? CNT_W + 1 : 17;

  logic [7:0]    link_len;
  logic [7:0]    t_start;
  logic [7:0]    tcp_data;
  logic [AW-1:0] n_w, l_w, t_w, iplen_w, trimmed;
  logic          ip_bad;
  logic          is_mms, is_iec104, is_sntp;
  efc_class_t    cls;
  efc_err_t      err;
  logic [7:0]    pos;
  logic [AW-1:0] valid;

  assign link_len = hdr.has_vlan_tag ? LINK_LEN_VLAN : LINK_LEN;
  assign t_start  = link_len + {2'b00, hdr.ip_header_words, 2'b00};
  assign tcp_data = t_start + {2'b00, hdr.tcp_header_words, 2'b00};

  assign n_w     = AW'(count);
  assign l_w     = AW'(link_len);
  assign t_w     = AW'(t_start);
  assign iplen_w = AW'(hdr.ip_total_length);
  assign trimmed = l_w + iplen_w;
  assign ip_bad  = (n_w < l_w + AW'(IP_HDR_MIN)) || (trimmed > n_w);

  assign is_mms    = (hdr.source_port == ports.mms_port)
                  || (hdr.dest_port == ports.mms_port);
  assign is_iec104 = (hdr.source_port == ports.iec104_port)
                  || (hdr.dest_port == ports.iec104_port);
  assign is_sntp   = (hdr.source_port == ports.sntp_port)
                  || (hdr.dest_port == ports.sntp_port);

  always_comb begin
    cls   = CLS_OTHER;
    err   = ERR_NONE;
    pos   = link_len;
    valid = n_w;
    unique case (hdr.ether_kind)
      ETH_IPV4: begin
        cls = CLS_IP;
        if (ip_bad) begin
          err = ERR_IP_LEN;
        end else begin
          valid = trimmed;
          priority if (hdr.ip_protocol == IPP_TCP) begin
            cls = CLS_TCP;
            pos = t_start;
            if (n_w < t_w + AW'(TCP_HDR_MIN)) begin
              err = ERR_TCP_SHORT;
            end else if (is_mms) begin
              cls = CLS_MMS;
              pos = tcp_data;
            end else if (is_iec104) begin
              cls = CLS_IEC104;
              pos = tcp_data;
            end
          end else if (hdr.ip_protocol == IPP_UDP) begin
            // a short UDP header still classifies by the port bytes seen
            if (n_w < t_w + AW'(UDP_HDR_LEN)) begin
              err = ERR_UDP_SHORT;
            end
            if (is_sntp) begin
              cls = CLS_SNTP;
              pos = t_start + UDP_HDR_LEN;
            end else begin
              cls = CLS_UDP;
              pos = t_start;
            end
          end else if (hdr.ip_protocol == IPP_ICMP) begin
            cls = CLS_ICMP;
            pos = t_start;
          end else begin
            cls = CLS_IP;
          end
        end
      end
      ETH_ARP:   cls = CLS_ARP;
      ETH_GOOSE: cls = CLS_GOOSE;
      ETH_SV:    cls = CLS_SV;
      ETH_PTP:   cls = CLS_PTP;
      default:   cls = CLS_OTHER;
    endcase
    if (err != ERR_NONE) begin
      pos = '0;
    end
  end

  assign result.protocol_class = cls;
  assign result.format_error   = err;
  assign result.payload_start  = pos;
  assign result.valid_bytes    = valid[11:0];

endmodule
`default_nettype wire

// ===== src/ethernet_frame_classifier.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ethernet_frame_classifier
// Byte-stream Ethernet classifier: optional 802.1Q tag, ethertype split,
// IPv4 length check and trim, TCP/UDP/ICMP split with port matching.
// ----------------------------------------------------------------------------
// Takes one frame byte per clock while in_ready is high, with no gaps needed
// between frames. Each byte updates the header fields; the byte marked last
// also loads a frame summary register, from which the classified result is
// loaded into the output register when that register is empty or being read.
// in_ready only drops when a finished summary and a finished result are both
// held because out_ready is low.
// Port registers take effect for frames classified after the write.
module ethernet_frame_classifier #(
  parameter int MAX_FRAME_BYTES = 2048
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire efc_pkg::efc_in_t                 in_item,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output efc_pkg::efc_out_t                     out_item,
  input  wire logic                             cfg_we,
  input  wire logic [efc_pkg::REG_IDX_W-1:0]    cfg_index,
  input  wire logic [15:0]                      cfg_wdata
);
  import efc_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

  efc_ports_t       ports_r;
  logic             out_valid_r;
  efc_out_t         out_item_r;

  logic             in_take;
  logic             sum_valid;
  logic             sum_take;
  efc_hdr_t         sum_hdr;
  logic [CNT_W-1:0] sum_count;
  efc_out_t         result;

  assign sum_take = sum_valid && (!out_valid_r || out_ready);
  assign in_ready = !sum_valid || sum_take;
  assign in_take  = in_valid && in_ready;

  efc_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_take   (in_take),
    .in_item   (in_item),
    .sum_take  (sum_take),
    .sum_valid (sum_valid),
    .sum_hdr   (sum_hdr),
    .sum_count (sum_count)
  );

  efc_classifier #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_classifier (
    .hdr    (sum_hdr),
    .count  (sum_count),
    .ports  (ports_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ports_r.mms_port    <= MMS_PORT_RST;
      ports_r.iec104_port <= IEC104_PORT_RST;
      ports_r.sntp_port   <= SNTP_PORT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MMS_PORT:    ports_r.mms_port    <= cfg_wdata;
        REG_IEC104_PORT: ports_r.iec104_port <= cfg_wdata;
        REG_SNTP_PORT:   ports_r.sntp_port   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sum_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_take) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Input stalls only with both the summary and the result held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (sum_valid && out_valid_r && !out_ready))
    else $error("input stalled without a held result");

  // A last byte always leaves a frame summary behind
  a_last_loads_summary: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_item.last_byte) |=> sum_valid)
    else $error("last byte taken but no frame summary");

  // Any format error clears the payload offset
  a_err_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.format_error != ERR_NONE)
      |-> (out_item_r.payload_start == 8'd0))
    else $error("payload offset set on a malformed frame");

  // A bad IP length is only reported on plain IP
  a_iplen_class: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.format_error == ERR_IP_LEN)
      |-> (out_item_r.protocol_class == CLS_IP))
    else $error("IP length error on a non-IP class");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams frames byte by byte into ethernet_frame_classifier and checks every
// frame result against a behavioural classifier kept alongside. Directed
// frames cover each class, tag handling and header faults; port registers,
// back-pressure and randomised traffic with varying source gaps and sink
// stalls follow.
// ----------------------------------------------------------------------------
module testbench;
  import efc_pkg::*;

  localparam int MAX_FRAME   = 2048;
  localparam int STUCK_LIMIT = 5000;
  localparam int MAX_GAP     = 200;
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  efc_in_t              in_item   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  efc_out_t             out_item;
  logic                 cfg_we    = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_wdata = '0;

  ethernet_frame_classifier #(.MAX_FRAME_BYTES(MAX_FRAME)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  efc_ports_t  port_regs = '{mms_port: MMS_PORT_RST, iec104_port: IEC104_PORT_RST,
                             sntp_port: SNTP_PORT_RST};
  efc_hdr_t    hdr = '0;
  int unsigned frame_len = 0;
  efc_out_t    frame_verdicts[$];
  efc_out_t    verdict;
  logic [7:0]  frame_buf[$];
  int          fail_count = 0;
  int          bytes_sent = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_off = 0;
  int          stuck_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sink: a long hold-off takes priority over random stalls
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off = hold_off - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (frame_verdicts.size() == 0) begin
        $error("result with no frame outstanding: protocol_class %0d",
               out_item.protocol_class);
        fail_count++;
      end else begin
        verdict = frame_verdicts.pop_front();
        if (out_item.protocol_class !== verdict.protocol_class) begin
          $error("protocol_class: expected %0d, got %0d",
                 verdict.protocol_class, out_item.protocol_class);
          fail_count++;
        end
        if (out_item.format_error !== verdict.format_error) begin
          $error("format_error: expected %0d, got %0d",
                 verdict.format_error, out_item.format_error);
          fail_count++;
        end
        if (out_item.payload_start !== verdict.payload_start) begin
          $error("payload_start: expected %0d, got %0d",
                 verdict.payload_start, out_item.payload_start);
          fail_count++;
        end
        if (out_item.valid_bytes !== verdict.valid_bytes) begin
          $error("valid_bytes: expected %0d, got %0d",
                 verdict.valid_bytes, out_item.valid_bytes);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("ethernet_frame_classifier test failed");
        $finish;
      end
    end
  end

  // Header capture: every field is taken from its offset as the byte arrives
  function automatic void absorb_byte(int unsigned idx, logic [7:0] b);
    int unsigned link_len;
    int unsigned tp;
    if (idx == 12) hdr.ether_kind = {b, 8'h00};
    if (idx == 13) begin
      hdr.ether_kind[7:0] = b;
      if (hdr.ether_kind == ETH_VLAN) begin
        hdr.has_vlan_tag = 1'b1;
        hdr.ether_kind   = '0;
      end
    end
    if (hdr.has_vlan_tag && idx == 16) hdr.ether_kind = {b, 8'h00};
    if (hdr.has_vlan_tag && idx == 17) hdr.ether_kind[7:0] = b;
    link_len = hdr.has_vlan_tag ? 32'(LINK_LEN_VLAN) : 32'(LINK_LEN);
    if (idx < link_len) return;
    if (idx == link_len) hdr.ip_header_words = b[3:0];
    if (idx == link_len + 2) hdr.ip_total_length[15:8] = b;
    if (idx == link_len + 3) hdr.ip_total_length[7:0] = b;
    if (idx == link_len + 9) hdr.ip_protocol = b;
    tp = link_len + 4 * int'(hdr.ip_header_words);
    if (idx == tp) hdr.source_port[15:8] = b;
    if (idx == tp + 1) hdr.source_port[7:0] = b;
    if (idx == tp + 2) hdr.dest_port[15:8] = b;
    if (idx == tp + 3) hdr.dest_port[7:0] = b;
    if (idx == tp + 12) hdr.tcp_header_words = b[7:4];
  endfunction

  function automatic efc_out_t classify_frame();
    int n, l, t, pos, valid, rest, iplen;
    efc_class_t cls;
    efc_err_t err;
    efc_out_t r;
    n     = frame_len;
    l     = hdr.has_vlan_tag ? int'(LINK_LEN_VLAN) : int'(LINK_LEN);
    t     = l + 4 * int'(hdr.ip_header_words);
    pos   = l;
    valid = n;
    cls   = CLS_OTHER;
    err   = ERR_NONE;
    case (hdr.ether_kind)
      ETH_IPV4: begin
        cls   = CLS_IP;
        rest  = n - l;
        iplen = int'(hdr.ip_total_length);
        if (rest < int'(IP_HDR_MIN) || iplen > rest) begin
          err = ERR_IP_LEN;
        end else begin
          valid = l + iplen;
          if (hdr.ip_protocol == IPP_TCP) begin
            cls = CLS_TCP;
            pos = t;
            if (n - t < int'(TCP_HDR_MIN)) begin
              err = ERR_TCP_SHORT;
            end else if (hdr.source_port == port_regs.mms_port ||
                         hdr.dest_port == port_regs.mms_port) begin
              cls = CLS_MMS;
              pos = t + 4 * int'(hdr.tcp_header_words);
            end else if (hdr.source_port == port_regs.iec104_port ||
                         hdr.dest_port == port_regs.iec104_port) begin
              cls = CLS_IEC104;
              pos = t + 4 * int'(hdr.tcp_header_words);
            end
          end else if (hdr.ip_protocol == IPP_UDP) begin
            if (n - t < int'(UDP_HDR_LEN)) err = ERR_UDP_SHORT;
            if (hdr.source_port == port_regs.sntp_port ||
                hdr.dest_port == port_regs.sntp_port) begin
              cls = CLS_SNTP;
              pos = t + int'(UDP_HDR_LEN);
            end else begin
              cls = CLS_UDP;
              pos = t;
            end
          end else if (hdr.ip_protocol == IPP_ICMP) begin
            cls = CLS_ICMP;
            pos = t;
          end
        end
      end
      ETH_ARP:   cls = CLS_ARP;
      ETH_GOOSE: cls = CLS_GOOSE;
      ETH_SV:    cls = CLS_SV;
      ETH_PTP:   cls = CLS_PTP;
      default:   cls = CLS_OTHER;
    endcase
    if (err != ERR_NONE) pos = 0;
    if (valid < 0) valid = 0;
    r.protocol_class = cls;
    r.format_error   = err;
    r.payload_start  = pos[7:0];
    r.valid_bytes    = valid[11:0];
    return r;
  endfunction

  // Bytes past the size limit are dropped uncounted
  function automatic void track_byte(logic [7:0] b, logic last);
    if (frame_len < MAX_FRAME) begin
      absorb_byte(frame_len, b);
      frame_len++;
    end
    if (last) begin
      frame_verdicts.push_back(classify_frame());
      hdr       = '0;
      frame_len = 0;
    end
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(5))
      0:       return port_regs.mms_port;
      1:       return port_regs.iec104_port;
      2:       return port_regs.sntp_port;
      3:       return 16'h0000;
      4:       return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic void compose_frame(bit with_tag, logic [15:0] etype, logic [3:0] ihl,
                                        logic [7:0] proto, logic [15:0] sport,
                                        logic [15:0] dport, logic [3:0] doff,
                                        int body, int pad, int len_adj);
    logic [7:0] l3[$];
    int hl, tl, l3_len, tot;
    frame_buf.delete();
    repeat (12) frame_buf.push_back(rand_byte());
    if (with_tag) begin
      frame_buf.push_back(ETH_VLAN[15:8]);
      frame_buf.push_back(ETH_VLAN[7:0]);
      frame_buf.push_back(rand_byte());
      frame_buf.push_back(rand_byte());
    end
    frame_buf.push_back(etype[15:8]);
    frame_buf.push_back(etype[7:0]);
    if (etype == ETH_IPV4) begin
      hl = 4 * int'(ihl);
      if (proto == IPP_TCP) tl = (doff > 4) ? 4 * int'(doff) : 20;
      else if (proto == IPP_UDP) tl = 8;
      else tl = 0;
      l3_len = hl + tl + body;
      if (l3_len < 20) l3_len = 20;
      repeat (l3_len) l3.push_back(rand_byte());
      if (tl > 0) begin
        l3[hl]     = sport[15:8];
        l3[hl + 1] = sport[7:0];
        l3[hl + 2] = dport[15:8];
        l3[hl + 3] = dport[7:0];
      end
      if (proto == IPP_TCP) l3[hl + 12] = {doff, 4'h0};
      // IP fields last: with a tiny header they overwrite the transport bytes
      tot   = l3_len + len_adj;
      l3[0] = {4'h4, ihl};
      l3[2] = tot[15:8];
      l3[3] = tot[7:0];
      l3[9] = proto;
      foreach (l3[i]) frame_buf.push_back(l3[i]);
    end else begin
      repeat (body) frame_buf.push_back(rand_byte());
    end
    repeat (pad) frame_buf.push_back(rand_byte());
  endfunction

  function automatic void chop_frame(int n);
    if (n < frame_buf.size()) frame_buf = frame_buf[0:n-1];
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gaps;
    gaps = 0;
    while (gaps < MAX_GAP && $urandom_range(99) < send_idle_pct) gaps++;
    @(negedge clk);
    if (gaps > 0) begin
      in_valid <= 1'b0;
      repeat (gaps) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{frame_byte: b, last_byte: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    track_byte(b, last);
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  // Drop valid, wait for every result, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frame_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MMS_PORT:    port_regs.mms_port = val;
      REG_IEC104_PORT: port_regs.iec104_port = val;
      REG_SNTP_PORT:   port_regs.sntp_port = val;
      default: ;
    endcase
  endtask

  task automatic random_frame();
    int kind, mode, len_adj;
    bit with_tag;
    logic [15:0] etype;
    logic [7:0] proto;
    logic [3:0] ihl, doff;
    kind     = $urandom_range(9);
    mode     = $urandom_range(99);
    with_tag = ($urandom_range(3) == 0);
    if (kind < 6) etype = ETH_IPV4;
    else if (kind == 6) etype = ETH_ARP;
    else if (kind == 7) begin
      case ($urandom_range(2))
        0:       etype = ETH_GOOSE;
        1:       etype = ETH_SV;
        default: etype = ETH_PTP;
      endcase
    end else if (kind == 8) etype = ETH_VLAN;
    else etype = 16'($urandom_range(16'hFFFF));
    case ($urandom_range(6))
      0, 1, 2: proto = IPP_TCP;
      3, 4:    proto = IPP_UDP;
      5:       proto = IPP_ICMP;
      default: proto = rand_byte();
    endcase
    ihl     = ($urandom_range(3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
    doff    = 4'($urandom_range(5, 15));
    len_adj = 0;
    // Most frames well formed; the rest with odd lengths, cut short or junk
    if (mode >= 80 && mode < 88) begin
      ihl     = 4'($urandom_range(15));
      len_adj = int'($urandom_range(16)) - 8;
    end else if (mode >= 88 && mode < 92) begin
      len_adj = int'($urandom_range(16'hFFFF));
    end
    compose_frame(with_tag, etype, ihl, proto, pick_port(), pick_port(), doff,
                  $urandom_range(12), ($urandom_range(3) == 0) ? $urandom_range(1, 8) : 0,
                  len_adj);
    if (mode >= 92 && mode < 97) begin
      chop_frame($urandom_range(1, frame_buf.size()));
    end else if (mode >= 97) begin
      frame_buf.delete();
      repeat ($urandom_range(1, 60)) frame_buf.push_back(rand_byte());
    end
    send_frame();
  endtask

  task automatic test_link_types();
    // ends with only the upper ethertype byte in
    compose_frame(0, ETH_IPV4, 5, IPP_TCP, 0, 0, 5, 0, 0, 0);
    chop_frame(13);
    send_frame();
    compose_frame(0, ETH_ARP, 5, IPP_TCP, 0, 0, 5, 0, 0, 0);
    send_frame();
    compose_frame(0, ETH_GOOSE, 5, IPP_TCP, 0, 0, 5, 0, 0, 0);
    send_frame();
    compose_frame(0, ETH_SV, 5, IPP_TCP, 0, 0, 5, 0, 0, 0);
    send_frame();
    compose_frame(0, ETH_PTP, 5, IPP_TCP, 0, 0, 5, 0, 0, 0);
    send_frame();
    compose_frame(0, 16'hFFFF, 5, IPP_TCP, 0, 0, 5, 0, 0, 0);
    send_frame();
  endtask

  task automatic test_vlan();
    compose_frame(1, ETH_IPV4, 5, IPP_TCP, 16'd5000, MMS_PORT_RST, 5, 0, 0, 0);
    send_frame();
    // tagged frame cut inside the inner ethertype
    compose_frame(1, ETH_IPV4, 5, IPP_TCP, 0, 0, 5, 0, 0, 0);
    chop_frame(17);
    send_frame();
    // stacked tags: inner tag is not skipped
    compose_frame(1, ETH_VLAN, 5, IPP_TCP, 0, 0, 5, 0, 0, 0);
    send_frame();
  endtask

  task automatic test_ipv4_transport();
    compose_frame(0, ETH_IPV4, 5, IPP_UDP, 16'd1000, SNTP_PORT_RST, 5, 0, 0, 0);
    send_frame();
    compose_frame(0, ETH_IPV4, 5, IPP_ICMP, 0, 0, 5, 0, 0, 0);
    send_frame();
    compose_frame(0, ETH_IPV4, 5, 8'hFF, 0, 0, 5, 0, 0, 0);
    send_frame();
    // trailing padding beyond the IP total length is trimmed
    compose_frame(0, ETH_IPV4, 5, IPP_UDP, 16'd7, 16'd9, 5, 0, 4, 0);
    send_frame();
    // deepest payload offset: tag, longest IP and TCP headers
    compose_frame(1, ETH_IPV4, 15, IPP_TCP, MMS_PORT_RST, 16'd1, 15, 0, 0, 0);
    send_frame();
    // zero header length: IP and TCP fields overlap
    compose_frame(0, ETH_IPV4, 0, IPP_TCP, 16'd1, 16'd2, 5, 0, 0, 0);
    send_frame();
  endtask

  task automatic test_ipv4_errors();
    compose_frame(0, ETH_IPV4, 5, IPP_TCP, 0, 0, 5, 0, 0, 0);
    chop_frame(33);
    send_frame();
    // TCP short after trimming: valid_bytes keeps the trimmed length
    compose_frame(0, ETH_IPV4, 5, IPP_TCP, 16'd1, 16'd2, 5, 0, 0, -10);
    chop_frame(50);
    send_frame();
    compose_frame(0, ETH_IPV4, 5, IPP_UDP, 16'd1, SNTP_PORT_RST, 5, 0, 0, -4);
    chop_frame(38);
    send_frame();
    // UDP short with only the source port in
    compose_frame(0, ETH_IPV4, 5, IPP_UDP, 16'd1, 16'd2, 5, 0, 0, -6);
    chop_frame(36);
    send_frame();
  endtask

  task automatic test_port_registers();
    settle();
    write_reg(REG_MMS_PORT, 16'h0000);
    write_reg(REG_IEC104_PORT, 16'hFFFF);
    write_reg(REG_SNTP_PORT, 16'h0000);
    write_reg(REG_SPARE, 16'h1234);
    compose_frame(0, ETH_IPV4, 5, IPP_TCP, 16'h0000, 16'd5, 5, 0, 0, 0);
    send_frame();
    compose_frame(0, ETH_IPV4, 5, IPP_TCP, 16'd7, 16'hFFFF, 5, 0, 0, 0);
    send_frame();
    compose_frame(0, ETH_IPV4, 5, IPP_UDP, 16'd9, 16'h0000, 5, 0, 0, 0);
    send_frame();
    settle();
    write_reg(REG_MMS_PORT, 16'hFFFF);
    write_reg(REG_IEC104_PORT, 16'h0000);
    write_reg(REG_SNTP_PORT, 16'hFFFF);
    // both port registers match: MMS wins
    compose_frame(0, ETH_IPV4, 5, IPP_TCP, 16'h0000, 16'hFFFF, 7, 0, 0, 0);
    send_frame();
    compose_frame(0, ETH_IPV4, 5, IPP_UDP, 16'hFFFF, 16'd3, 5, 0, 0, 0);
    send_frame();
  endtask

  task automatic test_backpressure();
    settle();
    send_idle_pct = 0;
    stall_pct     = 0;
    // hold the sink while short frames keep coming, so the input stalls
    hold_off = 300;
    repeat (40) send_byte(rand_byte(), 1'b1);
  endtask

  task automatic test_random_traffic(input int src_idle, input int sink_stall);
    int frames, start_bytes;
    settle();
    send_idle_pct = src_idle;
    stall_pct     = sink_stall;
    write_reg(REG_MMS_PORT, 16'($urandom_range(16'hFFFF)));
    write_reg(REG_IEC104_PORT, 16'($urandom_range(16'hFFFF)));
    write_reg(REG_SNTP_PORT, 16'($urandom_range(16'hFFFF)));
    frames      = 0;
    start_bytes = bytes_sent;
    while (frames < 1 || bytes_sent - start_bytes < 60) begin
      random_frame();
      frames++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_link_types();
    test_vlan();
    test_ipv4_transport();
    test_ipv4_errors();
    test_port_registers();
    test_backpressure();
    test_random_traffic(0, 0);
    test_random_traffic(85, 0);
    test_random_traffic(0, 85);
    test_random_traffic(12, 12);
    settle();
    repeat (10) @(posedge clk);
    fail_count += frame_verdicts.size();
    if (fail_count == 0) begin
      $display("ethernet_frame_classifier test passed");
    end else begin
      $display("ethernet_frame_classifier test failed");
    end
    $finish;
  end

endmodule
